// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside of reset
`define ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== design/vspa_pkg.sv =====
// ---------------------------------------------------------------------------
// vspa_pkg
// shared types, widths, register indexes and reset values of the
// vital sign persistence alarm unit
// ---------------------------------------------------------------------------
package vspa_pkg;

   // field widths
   localparam int TIME_W   = 32;
   localparam int HR_W     = 8;
   localparam int OX_W     = 10;
   localparam int MLIM_W   = 15;
   localparam int HOLD_W   = 24;
   localparam int ACC_W    = 16;
   localparam int SQ_W     = 31;
   localparam int MAG_W    = 32;
   localparam int LIMSQ_W  = 2 * MLIM_W;
   localparam int GOOD_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OXYGEN_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTION_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HOLD_MS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OXYGEN_HOLD_MS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTION_HOLD_MS = 3'd5;

   // register reset values
   localparam logic [HR_W-1:0]   PULSE_LIMIT_RST    = 8'd120;
   localparam logic [OX_W-1:0]   OXYGEN_LIMIT_RST   = 10'd1000;
   localparam logic [MLIM_W-1:0] MOTION_LIMIT_RST   = 15'd2000;
   localparam logic [HOLD_W-1:0] PULSE_HOLD_MS_RST  = 24'd60000;
   localparam logic [HOLD_W-1:0] OXYGEN_HOLD_MS_RST = 24'd120000;
   localparam logic [HOLD_W-1:0] MOTION_HOLD_MS_RST = 24'd30000;

   // default parameter values
   localparam int PULSE_CLEAR_COUNT_DEF  = 3;
   localparam int OXYGEN_CLEAR_COUNT_DEF = 5;
   localparam int MOTION_CLEAR_COUNT_DEF = 2;
   localparam int QUEUE_DEPTH_DEF        = 4;

   // configuration registers
   typedef struct packed {
      logic [HR_W-1:0]   pulse_limit;
      logic [OX_W-1:0]   oxygen_limit;
      logic [MLIM_W-1:0] motion_limit;
      logic [HOLD_W-1:0] pulse_hold_ms;
      logic [HOLD_W-1:0] oxygen_hold_ms;
      logic [HOLD_W-1:0] motion_hold_ms;
   } cfg_type;

   // one evaluation as it arrives
   typedef struct packed {
      logic [TIME_W-1:0]       now_ms;
      logic                    node1_fresh;
      logic                    node2_fresh;
      logic [HR_W-1:0]         heart_rate;
      logic                    heart_rate_valid;
      logic [OX_W-1:0]         oxygen_tenths;
      logic signed [ACC_W-1:0] node1_acc_x;
      logic signed [ACC_W-1:0] node1_acc_y;
      logic signed [ACC_W-1:0] node1_acc_z;
      logic signed [ACC_W-1:0] node2_acc_x;
      logic signed [ACC_W-1:0] node2_acc_y;
      logic signed [ACC_W-1:0] node2_acc_z;
   } raw_item_type;

   // per channel evaluation command
   typedef struct packed {
      logic eval;
      logic high;
   } chan_cmd_type;

   // classified evaluation, front to back
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      chan_cmd_type      pulse;
      chan_cmd_type      oxygen;
      chan_cmd_type      motion;
      logic [HR_W-1:0]   heart_rate;
      logic [OX_W-1:0]   oxygen_tenths;
   } class_item_type;

endpackage

// ===== design/vital_sign_persistence_alarm_unit.sv =====
// ---------------------------------------------------------------------------
// vital_sign_persistence_alarm_unit
// persistence alarm on pulse, SpO2 and motion with hold times and clearing
// ---------------------------------------------------------------------------
// Each accepted item is one evaluation and yields exactly one result item,
// in order. The unit sustains one item per clock cycle while the output
// side is ready; a result item passes the stage-one register, the queue
// and the output register, is offered on rsp_valid and held until taken.
// The front stage squares the six accelerations into its stage-one
// register, then sums and classifies; classified items wait in a queue of
// QUEUE_DEPTH entries, and req_ready drops only when that queue and the
// front stage together hold QUEUE_DEPTH items. The back steps the three
// alarm channels once per item into the output register. Configuration
// writes are registered, the squared motion limit in a second register;
// the user must make them only while no item is in flight; not enforced.
// ---------------------------------------------------------------------------
module vital_sign_persistence_alarm_unit import vspa_pkg::*; #(
   parameter int PULSE_CLEAR_COUNT  = PULSE_CLEAR_COUNT_DEF,
   parameter int OXYGEN_CLEAR_COUNT = OXYGEN_CLEAR_COUNT_DEF,
   parameter int MOTION_CLEAR_COUNT = MOTION_CLEAR_COUNT_DEF,
   parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   // input items
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [TIME_W-1:0]       req_now_ms,
   input  logic                    req_node1_fresh,
   input  logic                    req_node2_fresh,
   input  logic [HR_W-1:0]         req_heart_rate,
   input  logic                    req_heart_rate_valid,
   input  logic [OX_W-1:0]         req_oxygen_tenths,
   input  logic signed [ACC_W-1:0] req_node1_acc_x,
   input  logic signed [ACC_W-1:0] req_node1_acc_y,
   input  logic signed [ACC_W-1:0] req_node1_acc_z,
   input  logic signed [ACC_W-1:0] req_node2_acc_x,
   input  logic signed [ACC_W-1:0] req_node2_acc_y,
   input  logic signed [ACC_W-1:0] req_node2_acc_z,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_pulse_alarm,
   output logic                    rsp_oxygen_alarm,
   output logic                    rsp_motion_alarm,
   output logic                    rsp_any_alarm,
   output logic [HR_W-1:0]         rsp_shown_heart_rate,
   output logic [OX_W-1:0]         rsp_shown_oxygen
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type          cfg_ff;
   raw_item_type     raw;
   logic             push, pop, empty;
   class_item_type   push_item, head;
   logic [CW-1:0]    queue_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_limit    <= PULSE_LIMIT_RST;
         cfg_ff.oxygen_limit   <= OXYGEN_LIMIT_RST;
         cfg_ff.motion_limit   <= MOTION_LIMIT_RST;
         cfg_ff.pulse_hold_ms  <= PULSE_HOLD_MS_RST;
         cfg_ff.oxygen_hold_ms <= OXYGEN_HOLD_MS_RST;
         cfg_ff.motion_hold_ms <= MOTION_HOLD_MS_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PULSE_LIMIT:    cfg_ff.pulse_limit    <= csr_write_data[HR_W-1:0];
            CSR_OXYGEN_LIMIT:   cfg_ff.oxygen_limit   <= csr_write_data[OX_W-1:0];
            CSR_MOTION_LIMIT:   cfg_ff.motion_limit   <= csr_write_data[MLIM_W-1:0];
            CSR_PULSE_HOLD_MS:  cfg_ff.pulse_hold_ms  <= csr_write_data[HOLD_W-1:0];
            CSR_OXYGEN_HOLD_MS: cfg_ff.oxygen_hold_ms <= csr_write_data[HOLD_W-1:0];
            CSR_MOTION_HOLD_MS: cfg_ff.motion_hold_ms <= csr_write_data[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // gather the input fields
   always_comb begin
      raw.now_ms           = req_now_ms;
      raw.node1_fresh      = req_node1_fresh;
      raw.node2_fresh      = req_node2_fresh;
      raw.heart_rate       = req_heart_rate;
      raw.heart_rate_valid = req_heart_rate_valid;
      raw.oxygen_tenths    = req_oxygen_tenths;
      raw.node1_acc_x      = req_node1_acc_x;
      raw.node1_acc_y      = req_node1_acc_y;
      raw.node1_acc_z      = req_node1_acc_z;
      raw.node2_acc_x      = req_node2_acc_x;
      raw.node2_acc_y      = req_node2_acc_y;
      raw.node2_acc_z      = req_node2_acc_z;
   end

   vspa_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .raw         (raw),
      .cfg         (cfg_ff),
      .queue_count (queue_count),
      .push        (push),
      .push_item   (push_item)
   );

   vspa_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .count     (queue_count)
   );

   vspa_back #(
      .PULSE_CLEAR_COUNT  (PULSE_CLEAR_COUNT),
      .OXYGEN_CLEAR_COUNT (OXYGEN_CLEAR_COUNT),
      .MOTION_CLEAR_COUNT (MOTION_CLEAR_COUNT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .empty                (empty),
      .pop                  (pop),
      .cfg                  (cfg_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pulse_alarm      (rsp_pulse_alarm),
      .rsp_oxygen_alarm     (rsp_oxygen_alarm),
      .rsp_motion_alarm     (rsp_motion_alarm),
      .rsp_any_alarm        (rsp_any_alarm),
      .rsp_shown_heart_rate (rsp_shown_heart_rate),
      .rsp_shown_oxygen     (rsp_shown_oxygen)
   );

endmodule

// ===== design/vspa_front.sv =====
// ---------------------------------------------------------------------------
// vspa_front
// accepts evaluations, squares the accelerations and classifies each
// channel sample as evaluated and high, then pushes into the queue
// ---------------------------------------------------------------------------
module vspa_front import vspa_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  raw_item_type                       raw,
   input  cfg_type                            cfg,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
   output logic                               push,
   output class_item_type                     push_item
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      chan_cmd_type      pulse;
      chan_cmd_type      oxygen;
      logic              node1_fresh;
      logic              node2_fresh;
      logic [HR_W-1:0]   heart_rate;
      logic [OX_W-1:0]   oxygen_tenths;
      logic [SQ_W-1:0]   n1x_sq;
      logic [SQ_W-1:0]   n1y_sq;
      logic [SQ_W-1:0]   n1z_sq;
      logic [SQ_W-1:0]   n2x_sq;
      logic [SQ_W-1:0]   n2y_sq;
      logic [SQ_W-1:0]   n2z_sq;
   } stage_type;

   logic                     s1_valid_ff;
   stage_type                s1_ff;
   stage_type                s1_in;
   logic [LIMSQ_W-1:0]       lim_sq_ff;
   logic [CW:0]              in_flight;
   logic                     accept;
   logic signed [2*ACC_W-1:0] p1x, p1y, p1z, p2x, p2y, p2z;
   logic [MAG_W-1:0]         mag1, mag2;

   // credit: items in stage one plus items queued must leave a free slot
   assign in_flight = {1'b0, queue_count} + (CW+1)'(s1_valid_ff);
   assign req_ready = (in_flight < (CW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   // squares and scalar compares of stage one
   always_comb begin
      p1x = (2*ACC_W)'(raw.node1_acc_x) * (2*ACC_W)'(raw.node1_acc_x);
      p1y = (2*ACC_W)'(raw.node1_acc_y) * (2*ACC_W)'(raw.node1_acc_y);
      p1z = (2*ACC_W)'(raw.node1_acc_z) * (2*ACC_W)'(raw.node1_acc_z);
      p2x = (2*ACC_W)'(raw.node2_acc_x) * (2*ACC_W)'(raw.node2_acc_x);
      p2y = (2*ACC_W)'(raw.node2_acc_y) * (2*ACC_W)'(raw.node2_acc_y);
      p2z = (2*ACC_W)'(raw.node2_acc_z) * (2*ACC_W)'(raw.node2_acc_z);
      s1_in.now_ms        = raw.now_ms;
      s1_in.pulse.eval    = raw.node1_fresh && raw.heart_rate_valid;
      s1_in.pulse.high    = raw.heart_rate > cfg.pulse_limit;
      s1_in.oxygen.eval   = raw.node1_fresh;
      s1_in.oxygen.high   = raw.oxygen_tenths > cfg.oxygen_limit;
      s1_in.node1_fresh   = raw.node1_fresh;
      s1_in.node2_fresh   = raw.node2_fresh;
      s1_in.heart_rate    = raw.heart_rate;
      s1_in.oxygen_tenths = raw.oxygen_tenths;
      s1_in.n1x_sq        = p1x[SQ_W-1:0];
      s1_in.n1y_sq        = p1y[SQ_W-1:0];
      s1_in.n1z_sq        = p1z[SQ_W-1:0];
      s1_in.n2x_sq        = p2x[SQ_W-1:0];
      s1_in.n2y_sq        = p2y[SQ_W-1:0];
      s1_in.n2z_sq        = p2z[SQ_W-1:0];
   end

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // stage one payload and squared motion limit
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      lim_sq_ff <= LIMSQ_W'(cfg.motion_limit) * LIMSQ_W'(cfg.motion_limit);
   end

   // magnitude sums and motion classification
   always_comb begin
      mag1 = MAG_W'(s1_ff.n1x_sq) + MAG_W'(s1_ff.n1y_sq) + MAG_W'(s1_ff.n1z_sq);
      mag2 = MAG_W'(s1_ff.n2x_sq) + MAG_W'(s1_ff.n2y_sq) + MAG_W'(s1_ff.n2z_sq);
      push_item.now_ms        = s1_ff.now_ms;
      push_item.pulse         = s1_ff.pulse;
      push_item.oxygen        = s1_ff.oxygen;
      push_item.motion.eval   = 1'b1;
      push_item.motion.high   = (s1_ff.node1_fresh && (mag1 > MAG_W'(lim_sq_ff))) ||
                                (s1_ff.node2_fresh && (mag2 > MAG_W'(lim_sq_ff)));
      push_item.heart_rate    = s1_ff.heart_rate;
      push_item.oxygen_tenths = s1_ff.oxygen_tenths;
   end

   assign push = s1_valid_ff;

endmodule

// ===== design/vspa_queue.sv =====
// ---------------------------------------------------------------------------
// vspa_queue
// short first-in first-out queue of classified items between front and back
// ---------------------------------------------------------------------------
module vspa_queue import vspa_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  class_item_type                     push_item,
   input  logic                               pop,
   output class_item_type                     head,
   output logic                               empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   class_item_type      entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

// ===== design/vspa_channel.sv =====
// ---------------------------------------------------------------------------
// vspa_channel
// one alarm channel: run tracking with hold time and clearing by a count
// of consecutive good samples
// ---------------------------------------------------------------------------
module vspa_channel import vspa_pkg::*; #(
   parameter int CLEAR_COUNT = PULSE_CLEAR_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  chan_cmd_type        cmd,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [HOLD_W-1:0]   hold_ms,
   output logic                active_in
);

   logic                active_ff;
   logic                run_open_ff, run_open_in;
   logic [TIME_W-1:0]   run_start_ff, run_start_in;
   logic [GOOD_W-1:0]   good_count_ff, good_count_in;
   logic [GOOD_W-1:0]   good_inc;
   logic [TIME_W-1:0]   elapsed;

   // next state of the channel for this sample
   always_comb begin
      active_in     = active_ff;
      run_open_in   = run_open_ff;
      run_start_in  = run_start_ff;
      good_count_in = good_count_ff;
      good_inc      = good_count_ff + 1'b1;
      elapsed       = now_ms - run_start_ff;
      if (cmd.eval) begin
         if (cmd.high) begin
            good_count_in = '0;
            if (!active_ff) begin
               if (!run_open_ff) begin
                  run_open_in  = 1'b1;
                  run_start_in = now_ms;
               end else if (elapsed >= TIME_W'(hold_ms)) begin
                  active_in = 1'b1;
               end
            end
         end else begin
            run_open_in = 1'b0;
            if (active_ff) begin
               if (good_inc >= GOOD_W'(CLEAR_COUNT)) begin
                  active_in     = 1'b0;
                  good_count_in = '0;
               end else begin
                  good_count_in = good_inc;
               end
            end
         end
      end
   end

   // channel control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         run_open_ff   <= 1'b0;
         good_count_ff <= '0;
      end else if (step) begin
         active_ff     <= active_in;
         run_open_ff   <= run_open_in;
         good_count_ff <= good_count_in;
      end
   end

   // run start time, only read while a run is open
   always_ff @(posedge clock) begin
      if (step) begin
         run_start_ff <= run_start_in;
      end
   end

endmodule

// ===== design/vspa_back.sv =====
// ---------------------------------------------------------------------------
// vspa_back
// takes classified items from the queue, steps the three alarm channels
// and holds the result item in the output register
// ---------------------------------------------------------------------------
module vspa_back import vspa_pkg::*; #(
   parameter int PULSE_CLEAR_COUNT  = PULSE_CLEAR_COUNT_DEF,
   parameter int OXYGEN_CLEAR_COUNT = OXYGEN_CLEAR_COUNT_DEF,
   parameter int MOTION_CLEAR_COUNT = MOTION_CLEAR_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  class_item_type    head,
   input  logic              empty,
   output logic              pop,
   input  cfg_type           cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_pulse_alarm,
   output logic              rsp_oxygen_alarm,
   output logic              rsp_motion_alarm,
   output logic              rsp_any_alarm,
   output logic [HR_W-1:0]   rsp_shown_heart_rate,
   output logic [OX_W-1:0]   rsp_shown_oxygen
);

   logic              rsp_valid_ff;
   logic              pulse_alarm_ff, oxygen_alarm_ff, motion_alarm_ff, any_alarm_ff;
   logic [HR_W-1:0]   shown_hr_ff;
   logic [OX_W-1:0]   shown_ox_ff;
   logic              pulse_active_in, oxygen_active_in, motion_active_in;

   // take the next item when the output register is free or being emptied
   assign pop = !empty && (!rsp_valid_ff || rsp_ready);

   vspa_channel #(.CLEAR_COUNT(PULSE_CLEAR_COUNT)) u_pulse (
      .clock     (clock),
      .reset     (reset),
      .step      (pop),
      .cmd       (head.pulse),
      .now_ms    (head.now_ms),
      .hold_ms   (cfg.pulse_hold_ms),
      .active_in (pulse_active_in)
   );

   vspa_channel #(.CLEAR_COUNT(OXYGEN_CLEAR_COUNT)) u_oxygen (
      .clock     (clock),
      .reset     (reset),
      .step      (pop),
      .cmd       (head.oxygen),
      .now_ms    (head.now_ms),
      .hold_ms   (cfg.oxygen_hold_ms),
      .active_in (oxygen_active_in)
   );

   vspa_channel #(.CLEAR_COUNT(MOTION_CLEAR_COUNT)) u_motion (
      .clock     (clock),
      .reset     (reset),
      .step      (pop),
      .cmd       (head.motion),
      .now_ms    (head.now_ms),
      .hold_ms   (cfg.motion_hold_ms),
      .active_in (motion_active_in)
   );

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         pulse_alarm_ff  <= pulse_active_in;
         oxygen_alarm_ff <= oxygen_active_in;
         motion_alarm_ff <= motion_active_in;
         any_alarm_ff    <= pulse_active_in || oxygen_active_in || motion_active_in;
         shown_hr_ff     <= head.heart_rate;
         shown_ox_ff     <= head.oxygen_tenths;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pulse_alarm      = pulse_alarm_ff;
   assign rsp_oxygen_alarm     = oxygen_alarm_ff;
   assign rsp_motion_alarm     = motion_alarm_ff;
   assign rsp_any_alarm        = any_alarm_ff;
   assign rsp_shown_heart_rate = shown_hr_ff;
   assign rsp_shown_oxygen     = shown_ox_ff;

endmodule

// ===== design/vspa_checker.sv =====
// ---------------------------------------------------------------------------
// vspa_checker
// port level checks of the alarm unit, attached by bind
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vspa_checker import vspa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_ready,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_pulse_alarm,
   input  logic                    rsp_oxygen_alarm,
   input  logic                    rsp_motion_alarm,
   input  logic                    rsp_any_alarm,
   input  logic [HR_W-1:0]         rsp_shown_heart_rate,
   input  logic [OX_W-1:0]         rsp_shown_oxygen
);

   logic                      any_or;
   logic [4+HR_W+OX_W-1:0]    rsp_payload;

   // OR of the channel alarms and the whole result payload
   assign any_or      = rsp_pulse_alarm || rsp_oxygen_alarm || rsp_motion_alarm;
   assign rsp_payload = {rsp_pulse_alarm, rsp_oxygen_alarm, rsp_motion_alarm,
                         rsp_any_alarm, rsp_shown_heart_rate, rsp_shown_oxygen};

   // a stalled result item stays offered
   `ASSERT_RUN(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // a stalled result item keeps its payload
   `ASSERT_RUN(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload))

   // the indicator is the OR of the three channel alarms
   `ASSERT_RUN(a_any_or, clock, reset, rsp_valid |-> (rsp_any_alarm == any_or))

   // reset leaves no result pending and the input side open
   `ASSERT_ALWAYS(a_reset_clean, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind vital_sign_persistence_alarm_unit vspa_checker u_checker (.*);
